FILE: hw/rtl/adjacency_matrix_store_macros.svh
// Assertion macros for the adjacency matrix store.
`ifndef ADJACENCY_MATRIX_STORE_MACROS_SVH
`define ADJACENCY_MATRIX_STORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define AMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define AMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ams_pkg.sv
// Shared constants and codes for the adjacency matrix store.
`default_nettype none
package ams_pkg;
	localparam int MAX_VERTICES_DEF = 32;
	localparam int LIST_LENGTH_DEF  = 32;

	localparam int FUNC_W   = 2;
	localparam int VERTEX_W = 5;
	localparam int WEIGHT_W = 16;
	localparam int VALUE_W  = 17;
	localparam int STATUS_W = 2;
	localparam int VCOUNT_W = 6;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

	localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LIST = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_TRUNC = 2'd3;

	localparam logic [VALUE_W-1:0] VALUE_NONE = 17'h1FFFF;
	localparam logic [VALUE_W-1:0] VALUE_ZERO = 17'h00000;
endpackage
`default_nettype wire

FILE: hw/rtl/ams_wmem.sv
// Weight matrix memory: one write port, one registered read port.
`default_nettype none
module ams_wmem
	import ams_pkg::*;
#(
	parameter int ADDR_W = 10,
	parameter int DATA_W = WEIGHT_W
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);
	localparam int DEPTH = 2 ** ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: hw/rtl/ams_seq.sv
// Operation sequencer: clear sweep, edge writes, weight reads and row scans.
`default_nettype none
`include "adjacency_matrix_store_macros.svh"
module ams_seq
	import ams_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int LIST_LENGTH  = LIST_LENGTH_DEF,
	parameter int IDX_W        = $clog2(MAX_VERTICES),
	parameter int ADDR_W       = 2 * IDX_W,
	parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [FUNC_W-1:0]         func,
	input  wire logic [VERTEX_W-1:0]       vertex_a,
	input  wire logic [VERTEX_W-1:0]       vertex_b,
	input  wire logic [WEIGHT_W-1:0]       edge_weight,
	input  wire logic [CNT_W-1:0]          active_count,
	output logic                           busy,
	output logic                           mem_we,
	output logic      [ADDR_W-1:0]         mem_waddr,
	output logic      [WEIGHT_W-1:0]       mem_wdata,
	output logic                           mem_re,
	output logic      [ADDR_W-1:0]         mem_raddr,
	input  wire logic [WEIGHT_W-1:0]       mem_rdata,
	output logic                           result_valid,
	output logic signed [VALUE_W-1:0]      value_out,
	output logic      [STATUS_W-1:0]       status,
	output logic                           last
);
	localparam int KW = $clog2(LIST_LENGTH + 1);
	localparam int AW = (CNT_W > VERTEX_W) ? CNT_W : VERTEX_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADD2  = 3'd2;
	localparam logic [2:0] ST_RDW   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_PAD   = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [ADDR_W-1:0]   clr_q, clr_d;
	logic [IDX_W-1:0]    a_q, a_d, b_q, b_d;
	logic [WEIGHT_W-1:0] w_q, w_d;
	logic [CNT_W-1:0]    j_q, j_d;
	logic [IDX_W-1:0]    j_s1, j_s1_d;
	logic                vld_s1, vld_s1_d;
	logic [KW-1:0]       k_q, k_d;
	logic [IDX_W-1:0]    pend_q, pend_d;
	logic                trunc_q, trunc_d;
	logic                range_q, range_d;

	logic                       emit;
	logic signed [VALUE_W-1:0]  emit_value;
	logic [STATUS_W-1:0]        emit_status;
	logic                       emit_last;

	logic                       result_valid_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic [STATUS_W-1:0]        status_q;
	logic                       last_q;

	logic                accept, a_ok, b_ok, issue;
	logic [IDX_W-1:0]    a_idx, b_idx;
	logic [STATUS_W-1:0] pad_status;

	assign accept     = start && (state_q == ST_IDLE);
	assign a_ok       = AW'(vertex_a) < AW'(active_count);
	assign b_ok       = AW'(vertex_b) < AW'(active_count);
	assign a_idx      = IDX_W'(vertex_a);
	assign b_idx      = IDX_W'(vertex_b);
	assign issue      = (state_q == ST_SCAN) && (j_q < active_count);
	assign pad_status = range_q ? STATUS_RANGE : STATUS_OK;

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		a_d         = a_q;
		b_d         = b_q;
		w_d         = w_q;
		j_d         = j_q;
		j_s1_d      = j_s1;
		vld_s1_d    = 1'b0;
		k_d         = k_q;
		pend_d      = pend_q;
		trunc_d     = trunc_q;
		range_d     = range_q;
		mem_we      = 1'b0;
		mem_waddr   = {a_idx, b_idx};
		mem_wdata   = edge_weight;
		mem_re      = 1'b0;
		mem_raddr   = {a_idx, b_idx};
		emit        = 1'b0;
		emit_value  = VALUE_ZERO;
		emit_status = STATUS_OK;
		emit_last   = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_d     = clr_q + ADDR_W'(1);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (func)
						FUNC_ADD: begin
							if (!a_ok || !b_ok) begin
								emit        = 1'b1;
								emit_status = STATUS_RANGE;
							end else if (edge_weight == '0) begin
								emit        = 1'b1;
								emit_status = STATUS_ZERO;
							end else begin
								mem_we  = 1'b1;
								a_d     = a_idx;
								b_d     = b_idx;
								w_d     = edge_weight;
								state_d = ST_ADD2;
							end
						end
						FUNC_READ: begin
							if (!a_ok || !b_ok) begin
								emit        = 1'b1;
								emit_status = STATUS_RANGE;
							end else begin
								mem_re  = 1'b1;
								state_d = ST_RDW;
							end
						end
						FUNC_LIST: begin
							k_d     = '0;
							trunc_d = 1'b0;
							a_d     = a_idx;
							if (!a_ok) begin
								range_d = 1'b1;
								state_d = ST_PAD;
							end else begin
								range_d   = 1'b0;
								mem_re    = 1'b1;
								mem_raddr = {a_idx, IDX_W'(0)};
								j_d       = CNT_W'(1);
								j_s1_d    = '0;
								vld_s1_d  = 1'b1;
								state_d   = ST_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_ADD2: begin
				mem_we    = 1'b1;
				mem_waddr = {b_q, a_q};
				mem_wdata = w_q;
				emit      = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_RDW: begin
				emit       = 1'b1;
				emit_value = VALUE_W'(mem_rdata);
				state_d    = ST_IDLE;
			end
			ST_SCAN: begin
				vld_s1_d = issue;
				if (issue) begin
					mem_re    = 1'b1;
					mem_raddr = {a_q, j_q[IDX_W-1:0]};
					j_s1_d    = j_q[IDX_W-1:0];
					j_d       = j_q + CNT_W'(1);
				end
				if (vld_s1 && (mem_rdata != '0)) begin
					if (k_q < KW'(LIST_LENGTH - 1)) begin
						emit       = 1'b1;
						emit_value = VALUE_W'(j_s1);
						emit_last  = 1'b0;
						k_d        = k_q + KW'(1);
					end else if (k_q == KW'(LIST_LENGTH - 1)) begin
						pend_d = j_s1;
						k_d    = KW'(LIST_LENGTH);
					end else begin
						trunc_d = 1'b1;
					end
				end
				if (!issue && !vld_s1) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				emit = 1'b1;
				if (k_q < KW'(LIST_LENGTH - 1)) begin
					emit_value  = VALUE_NONE;
					emit_status = pad_status;
					emit_last   = 1'b0;
					k_d         = k_q + KW'(1);
				end else if (k_q == KW'(LIST_LENGTH - 1)) begin
					emit_value  = VALUE_NONE;
					emit_status = pad_status;
					k_d         = KW'(LIST_LENGTH);
					state_d     = ST_IDLE;
				end else begin
					emit_value  = VALUE_W'(pend_q);
					emit_status = trunc_q ? STATUS_TRUNC : STATUS_OK;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			vld_s1         <= 1'b0;
			k_q            <= '0;
			j_q            <= '0;
			trunc_q        <= 1'b0;
			range_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			clr_q          <= clr_d;
			vld_s1         <= vld_s1_d;
			k_q            <= k_d;
			j_q            <= j_d;
			trunc_q        <= trunc_d;
			range_q        <= range_d;
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		a_q    <= a_d;
		b_q    <= b_d;
		w_q    <= w_d;
		j_s1   <= j_s1_d;
		pend_q <= pend_d;
		if (emit) begin
			value_q  <= emit_value;
			status_q <= emit_status;
			last_q   <= emit_last;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign value_out    = value_q;
	assign status       = status_q;
	assign last         = last_q;

	`AMS_ASSERT_NOW(a_trunc_last, result_valid_q && status_q == STATUS_TRUNC, last_q, "truncation not on last result")
	`AMS_ASSERT_NOW(a_we_state, mem_we, state_q == ST_CLEAR || state_q == ST_IDLE || state_q == ST_ADD2, "write outside clear or add")
	`AMS_ASSERT_NOW(a_k_bound, state_q != ST_CLEAR, k_q <= KW'(LIST_LENGTH), "list count overrun")
	`AMS_ASSERT_NOW(a_s1_src, vld_s1, $past(mem_re), "scan stage without read")
	`AMS_ASSERT_NEXT(a_add_done, state_q == ST_ADD2, result_valid_q && last_q, "add transaction gave no result")
endmodule
`default_nettype wire

FILE: hw/rtl/adjacency_matrix_store.sv
// Top level of the weighted adjacency matrix store.
`default_nettype none
// Undirected weighted adjacency matrix with add-edge, read-weight and
// list-neighbour transactions. After reset the block sweeps the matrix to
// zero, one entry per cycle, over all 2**(2*clog2(MAX_VERTICES)) entries
// (1024 at the defaults) with busy high. A transaction is taken on start
// while busy is low. Add and read give one result each. A neighbour list
// for an in-range vertex_a scans the row through the single memory read
// port, one entry per cycle, then pads, giving LIST_LENGTH results. Results
// come on result_valid, at most one per cycle, and cannot be stalled; the
// receiver must take each one in the cycle it is shown.
module adjacency_matrix_store
	import ams_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int LIST_LENGTH  = LIST_LENGTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [VERTEX_W-1:0]   vertex_a,
	input  wire logic [VERTEX_W-1:0]   vertex_b,
	input  wire logic [WEIGHT_W-1:0]   edge_weight,
	input  wire logic                  cfg_wr_en,
	input  wire logic [VCOUNT_W-1:0]   cfg_wr_data,
	output logic                       result_valid,
	output logic signed [VALUE_W-1:0]  value_out,
	output logic      [STATUS_W-1:0]   status,
	output logic                       last
);
	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int CW     = (CNT_W > VCOUNT_W) ? CNT_W : VCOUNT_W;

	logic [VCOUNT_W-1:0] vertex_count_q;
	logic [CW-1:0]       vc_ext;
	logic [CNT_W-1:0]    active_count;

	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [WEIGHT_W-1:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	assign vc_ext       = CW'(vertex_count_q);
	assign active_count = (vc_ext > CW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
	                                                   : CNT_W'(vc_ext);

	ams_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.LIST_LENGTH  (LIST_LENGTH),
		.IDX_W        (IDX_W),
		.ADDR_W       (ADDR_W),
		.CNT_W        (CNT_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.edge_weight  (edge_weight),
		.active_count (active_count),
		.busy         (busy),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.result_valid (result_valid),
		.value_out    (value_out),
		.status       (status),
		.last         (last)
	);

	ams_wmem #(
		.ADDR_W (ADDR_W),
		.DATA_W (WEIGHT_W)
	) u_wmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule
`default_nettype wire
